/* rtl/mfek_pkg.sv */
// Shared types and constants of the Edmonds-Karp maximum-flow engine.
// Used by the channel interfaces and by the engine's top level.
package mfek_pkg;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_ADD     = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam int         TOTAL_BITS = 24;
    localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] capacity;
        logic [5:0]  source_node;
        logic [5:0]  sink_node;
    } cmd_t;

    typedef struct packed {
        logic [23:0] max_flow;
        logic        edges_dropped;
    } res_t;

endpackage

/* rtl/mfek_cmd_if.sv */
// Command channel of the maximum-flow engine: valid/ready with a cmd_t payload.
// Depends on mfek_pkg.
interface mfek_cmd_if;
    logic          valid;
    logic          ready;
    mfek_pkg::cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/mfek_res_if.sv */
// Result channel of the maximum-flow engine: valid/ready with a res_t payload.
// Depends on mfek_pkg.
interface mfek_res_if;
    logic          valid;
    logic          ready;
    mfek_pkg::res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/max_flow_edmonds_karp.sv */
// Edmonds-Karp maximum-flow engine: top level with its sequencer and stores.
// Depends on mfek_pkg, mfek_cmd_if, mfek_res_if and mfek_ram.
//
// Usage: commands arrive on cmd (valid/ready). A clear command empties the
// graph, an add-edge command stores an edge and its reverse residual edge, and
// a compute command returns one transaction on res with the maximum flow from
// source_node to sink_node and the dropped-edge flag. Clear and add produce
// no result.
// Sequencing: one sequencer walks single-port-read RAMs, so a clear, a compute
// or an add-edge that stores an edge runs through a series of states with
// cmd.ready low. Add-edge reads and writes the first-edge entry of from_node
// and then of to_node; clear sweeps the first-edge table. Each compute search
// sweeps the visited flags, dequeues nodes and scans their edges, then
// augments the path found edge by edge. After reset the first-edge table is
// swept with cmd.ready low. A finished result sits in an output register; the
// engine takes new commands while it waits, and a later result waits until the
// receiver has taken the earlier one.
module max_flow_edmonds_karp #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256,
    parameter int CAP_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mfek_cmd_if.sink   cmd,
    mfek_res_if.source res
);

    localparam int NIW   = $clog2(MAX_NODES);
    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int EW    = $clog2(SLOTS);
    localparam int LW    = EW + 1;
    localparam int CW    = $clog2(MAX_EDGES + 1);
    localparam int QW    = $clog2(MAX_NODES + 1);
    localparam int SW    = ((CAP_BITS > mfek_pkg::TOTAL_BITS) ?
                            CAP_BITS : mfek_pkg::TOTAL_BITS) + 1;
    localparam logic [LW-1:0] NO_EDGE = LW'(SLOTS);

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE,
        ST_ADD_RD_U, ST_ADD_WR_U, ST_ADD_RD_V, ST_ADD_WR_V,
        ST_BFS_CLR, ST_BFS_SEED, ST_BFS_POP, ST_BFS_U, ST_BFS_E, ST_BFS_V, ST_BFS_CHK,
        ST_AUG_B, ST_AUG_BL, ST_AUG_P, ST_AUG_E, ST_AUG_FWD, ST_AUG_REV, ST_AUG_HEAD,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [QW-1:0]          i_reg;
    logic [QW-1:0]          rd_reg;
    logic [QW-1:0]          wr_reg;
    logic [CW-1:0]          count_reg;
    logic                   ovf_reg;
    logic                   found_reg;
    logic [NIW-1:0]         u_reg;
    logic [NIW-1:0]         v_reg;
    logic [NIW-1:0]         s_reg;
    logic [NIW-1:0]         t_reg;
    logic [CAP_BITS-1:0]    cap_reg;
    logic [LW-1:0]          e_reg;
    logic [LW-1:0]          nx_reg;
    logic [CAP_BITS-1:0]    r_reg;
    logic [CAP_BITS-1:0]    bu_reg;
    logic [CAP_BITS-1:0]    b_reg;
    logic [23:0]            total_reg;
    logic                   res_valid_reg;
    mfek_pkg::res_t         res_reg;

    // RAM ports
    logic                   first_we;
    logic [NIW-1:0]         first_waddr, first_raddr;
    logic [LW-1:0]          first_wdata, first_rdata;
    logic                   edge_we;
    logic [EW-1:0]          edge_waddr, edge_raddr;
    logic [NIW-1:0]         head_wdata, head_rdata;
    logic [LW-1:0]          next_wdata, next_rdata;
    logic                   resid_we;
    logic [EW-1:0]          resid_waddr, resid_raddr;
    logic [CAP_BITS-1:0]    resid_wdata, resid_rdata;
    logic                   seen_we;
    logic [NIW-1:0]         seen_waddr;
    logic                   seen_wdata, seen_rdata;
    logic                   node_we;
    logic [NIW-1:0]         parent_raddr;
    logic [EW-1:0]          parent_rdata;
    logic [NIW-1:0]         bot_raddr;
    logic [CAP_BITS-1:0]    bot_wdata, bot_rdata;
    logic                   queue_we;
    logic [NIW-1:0]         queue_waddr;
    logic [NIW-1:0]         queue_wdata, queue_rdata;

    logic [EW-1:0]          slot;
    logic [EW-1:0]          e_mate;
    logic                   take;
    logic [SW-1:0]          sum;

    assign slot   = EW'({count_reg, 1'b0});
    assign e_mate = e_reg[EW-1:0] ^ EW'(1);
    assign take   = !seen_rdata && (r_reg != '0);
    assign sum    = SW'(total_reg) + SW'(b_reg);

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

    always_comb
    begin
        first_we = 1'b0; first_waddr = u_reg; first_wdata = NO_EDGE;
        first_raddr = u_reg;
        edge_we = 1'b0; edge_waddr = slot; head_wdata = v_reg; next_wdata = first_rdata;
        edge_raddr = e_reg[EW-1:0];
        resid_we = 1'b0; resid_waddr = slot; resid_wdata = cap_reg;
        resid_raddr = e_reg[EW-1:0];
        seen_we = 1'b0; seen_waddr = v_reg; seen_wdata = 1'b1;
        node_we = 1'b0; parent_raddr = v_reg; bot_raddr = u_reg;
        bot_wdata = r_reg;
        queue_we = 1'b0; queue_waddr = wr_reg[NIW-1:0]; queue_wdata = v_reg;
        case (state_reg)
            ST_CLR:
            begin
                first_we = 1'b1; first_waddr = i_reg[NIW-1:0];
            end
            ST_ADD_RD_U: first_raddr = u_reg;
            ST_ADD_WR_U:
            begin
                edge_we = 1'b1; resid_we = 1'b1;
                first_we = 1'b1; first_waddr = u_reg; first_wdata = LW'(slot);
            end
            ST_ADD_RD_V: first_raddr = v_reg;
            ST_ADD_WR_V:
            begin
                edge_we = 1'b1; edge_waddr = slot | EW'(1); head_wdata = u_reg;
                resid_we = 1'b1; resid_waddr = slot | EW'(1); resid_wdata = '0;
                first_we = 1'b1; first_waddr = v_reg; first_wdata = LW'(slot | EW'(1));
            end
            ST_BFS_CLR:
            begin
                seen_we = 1'b1; seen_waddr = i_reg[NIW-1:0]; seen_wdata = 1'b0;
            end
            ST_BFS_SEED:
            begin
                seen_we = 1'b1; seen_waddr = s_reg;
                queue_we = 1'b1; queue_waddr = '0; queue_wdata = s_reg;
            end
            ST_BFS_U:
            begin
                first_raddr = queue_rdata; bot_raddr = queue_rdata;
            end
            ST_BFS_E:
            begin
                edge_raddr  = first_rdata[EW-1:0];
                resid_raddr = first_rdata[EW-1:0];
            end
            ST_BFS_CHK:
            begin
                edge_raddr  = nx_reg[EW-1:0];
                resid_raddr = nx_reg[EW-1:0];
                if (take)
                begin
                    seen_we = 1'b1;
                    node_we = 1'b1;
                    if (r_reg < bu_reg || u_reg == s_reg)
                    begin
                        bot_wdata = r_reg;
                    end
                    else
                    begin
                        bot_wdata = bu_reg;
                    end
                    queue_we = (32'(wr_reg) < MAX_NODES);
                end
            end
            ST_AUG_B: bot_raddr = t_reg;
            ST_AUG_BL: parent_raddr = v_reg;
            ST_AUG_P: parent_raddr = v_reg;
            ST_AUG_E: resid_raddr = parent_rdata;
            ST_AUG_FWD:
            begin
                resid_we = 1'b1; resid_waddr = e_reg[EW-1:0];
                resid_wdata = resid_rdata - b_reg;
                resid_raddr = e_mate;
            end
            ST_AUG_REV:
            begin
                resid_we = 1'b1; resid_waddr = e_mate;
                resid_wdata = resid_rdata + b_reg;
                edge_raddr = e_mate;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            i_reg         <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            found_reg     <= 1'b0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // In ST_OUT the result register is handled by that state alone.
            if (res_valid_reg && res.ready && state_reg != ST_OUT)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR:
                begin
                    i_reg <= i_reg + QW'(1);
                    if (32'(i_reg) == MAX_NODES - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        u_reg   <= NIW'(cmd.payload.from_node);
                        v_reg   <= NIW'(cmd.payload.to_node);
                        cap_reg <= CAP_BITS'(cmd.payload.capacity);
                        s_reg   <= NIW'(cmd.payload.source_node);
                        t_reg   <= NIW'(cmd.payload.sink_node);
                        case (cmd.payload.action)
                            mfek_pkg::ACT_CLEAR:
                            begin
                                i_reg     <= '0;
                                count_reg <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= ST_CLR;
                            end
                            mfek_pkg::ACT_ADD:
                            begin
                                if (32'(cmd.payload.from_node) < MAX_NODES &&
                                    32'(cmd.payload.to_node) < MAX_NODES)
                                begin
                                    if (32'(count_reg) >= MAX_EDGES)
                                    begin
                                        ovf_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_ADD_RD_U;
                                    end
                                end
                            end
                            mfek_pkg::ACT_COMPUTE:
                            begin
                                total_reg <= '0;
                                i_reg     <= '0;
                                if (32'(cmd.payload.source_node) < MAX_NODES &&
                                    32'(cmd.payload.sink_node) < MAX_NODES &&
                                    cmd.payload.source_node != cmd.payload.sink_node)
                                begin
                                    state_reg <= ST_BFS_CLR;
                                end
                                else
                                begin
                                    state_reg <= ST_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ADD_RD_U: state_reg <= ST_ADD_WR_U;
                ST_ADD_WR_U: state_reg <= ST_ADD_RD_V;
                ST_ADD_RD_V: state_reg <= ST_ADD_WR_V;
                ST_ADD_WR_V:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_BFS_CLR:
                begin
                    i_reg <= i_reg + QW'(1);
                    if (32'(i_reg) == MAX_NODES - 1)
                    begin
                        state_reg <= ST_BFS_SEED;
                    end
                end
                ST_BFS_SEED:
                begin
                    rd_reg    <= '0;
                    wr_reg    <= QW'(1);
                    found_reg <= 1'b0;
                    state_reg <= ST_BFS_POP;
                end
                ST_BFS_POP:
                begin
                    if (found_reg)
                    begin
                        state_reg <= ST_AUG_B;
                    end
                    else if (rd_reg < wr_reg)
                    begin
                        rd_reg    <= rd_reg + QW'(1);
                        state_reg <= ST_BFS_U;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_BFS_U:
                begin
                    u_reg     <= queue_rdata;
                    state_reg <= ST_BFS_E;
                end
                ST_BFS_E:
                begin
                    bu_reg <= bot_rdata;
                    e_reg  <= first_rdata;
                    if (first_rdata == NO_EDGE)
                    begin
                        state_reg <= ST_BFS_POP;
                    end
                    else
                    begin
                        state_reg <= ST_BFS_V;
                    end
                end
                ST_BFS_V:
                begin
                    v_reg     <= head_rdata;
                    r_reg     <= resid_rdata;
                    nx_reg    <= next_rdata;
                    state_reg <= ST_BFS_CHK;
                end
                ST_BFS_CHK:
                begin
                    if (take)
                    begin
                        if (32'(wr_reg) < MAX_NODES)
                        begin
                            wr_reg <= wr_reg + QW'(1);
                        end
                        if (v_reg == t_reg)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    e_reg <= nx_reg;
                    if (nx_reg == NO_EDGE)
                    begin
                        state_reg <= ST_BFS_POP;
                    end
                    else
                    begin
                        state_reg <= ST_BFS_V;
                    end
                end
                ST_AUG_B:
                begin
                    v_reg     <= t_reg;
                    state_reg <= ST_AUG_BL;
                end
                ST_AUG_BL:
                begin
                    b_reg     <= bot_rdata;
                    state_reg <= ST_AUG_E;
                end
                ST_AUG_P: state_reg <= ST_AUG_E;
                ST_AUG_E:
                begin
                    e_reg     <= LW'(parent_rdata);
                    state_reg <= ST_AUG_FWD;
                end
                ST_AUG_FWD: state_reg <= ST_AUG_REV;
                ST_AUG_REV: state_reg <= ST_AUG_HEAD;
                ST_AUG_HEAD:
                begin
                    v_reg <= head_rdata;
                    if (head_rdata == s_reg)
                    begin
                        if (sum > SW'(mfek_pkg::TOTAL_MAX))
                        begin
                            total_reg <= mfek_pkg::TOTAL_MAX;
                        end
                        else
                        begin
                            total_reg <= 24'(sum);
                        end
                        i_reg     <= '0;
                        state_reg <= ST_BFS_CLR;
                    end
                    else
                    begin
                        state_reg <= ST_AUG_P;
                    end
                end
                ST_OUT:
                begin
                    if (!res_valid_reg || res.ready)
                    begin
                        res_valid_reg         <= 1'b1;
                        res_reg.max_flow      <= total_reg;
                        res_reg.edges_dropped <= ovf_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    mfek_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_first (
        .clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
        .raddr(first_raddr), .rdata(first_rdata)
    );

    mfek_ram #(.WIDTH(NIW), .DEPTH(SLOTS)) u_head (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(head_wdata),
        .raddr(edge_raddr), .rdata(head_rdata)
    );

    mfek_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(next_wdata),
        .raddr(edge_raddr), .rdata(next_rdata)
    );

    mfek_ram #(.WIDTH(CAP_BITS), .DEPTH(SLOTS)) u_resid (
        .clk(clk), .we(resid_we), .waddr(resid_waddr), .wdata(resid_wdata),
        .raddr(resid_raddr), .rdata(resid_rdata)
    );

    mfek_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_seen (
        .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
        .raddr(head_rdata), .rdata(seen_rdata)
    );

    mfek_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_parent (
        .clk(clk), .we(node_we), .waddr(v_reg), .wdata(e_reg[EW-1:0]),
        .raddr(parent_raddr), .rdata(parent_rdata)
    );

    mfek_ram #(.WIDTH(CAP_BITS), .DEPTH(MAX_NODES)) u_bot (
        .clk(clk), .we(node_we), .waddr(v_reg), .wdata(bot_wdata),
        .raddr(bot_raddr), .rdata(bot_rdata)
    );

    mfek_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(rd_reg[NIW-1:0]), .rdata(queue_rdata)
    );

endmodule

/* rtl/mfek_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mfek_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
